[rtl/qvr_pkg.sv]
// Shared constants and types for the quaternion vector rotation core.
package qvr_pkg;

  // Default number of fraction bits in the quaternion components
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // Field widths
  localparam int COORD_W = 16;
  localparam int QUAT_W  = 16;

  // Configuration port geometry
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Datapath widths
  localparam int PROD_W    = 2 * QUAT_W;   // 16x16 products
  localparam int SCALE_W   = PROD_W + 2;   // w*w - v.v and v.p
  localparam int CROSS_W   = PROD_W + 1;   // cross product terms
  localparam int TERM_W    = SCALE_W + COORD_W;
  localparam int SUM_MIN_W = 52;           // holds every full-precision sum

  // Reset values of the quaternion registers
  localparam logic [QUAT_W-1:0] QUAT_V_RESET = 16'h0000;
  localparam logic [QUAT_W-1:0] QUAT_W_RESET = 16'h4000;

  // Saturation limits
  localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
  localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;

  // Register map, word index
  typedef enum logic [1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } qvr_reg_t;

endpackage

[rtl/qvr_round_sat.sv]
// Round-to-nearest shift and 16-bit saturation of one biased sum.
module qvr_round_sat #(
  parameter int SUM_W = 52,
  parameter int SHIFT = 28
) (
  input  logic signed [SUM_W-1:0]          biased_sum,
  output logic signed [qvr_pkg::COORD_W-1:0] coord,
  output logic                             clip
);
  import qvr_pkg::*;

  localparam int Q_W   = SUM_W - SHIFT;
  localparam int EXT_W = (Q_W > COORD_W) ? Q_W : COORD_W;
  localparam logic signed [EXT_W-1:0] MAX_V = EXT_W'(32'sd32767);
  localparam logic signed [EXT_W-1:0] MIN_V = EXT_W'(-32'sd32768);

  logic signed [Q_W-1:0]   q_s;
  logic signed [EXT_W-1:0] q_ext;

  // Half unit is already added upstream; arithmetic shift floors
  assign q_s   = Q_W'(biased_sum >>> SHIFT);
  assign q_ext = EXT_W'(q_s);

  // Clip to the signed 16-bit range
  always_comb begin
    priority if (q_ext > MAX_V) begin
      coord = COORD_MAX;
      clip  = 1'b1;
    end else if (q_ext < MIN_V) begin
      coord = COORD_MIN;
      clip  = 1'b1;
    end else begin
      coord = COORD_W'(q_ext);
      clip  = 1'b0;
    end
  end

endmodule

[rtl/quaternion_vector_rotate_core.sv]
// Each accepted request passes through stages 1 to 5 in order; out_valid is the stage 5 valid,
//   and the result is taken at the edge where out_valid and out_ready are both high.
// Throughput: one request per cycle unless the output stalls; five register stages (products, sums,
//   wide products, final sum, round/saturate) each hold one request.
// A stall at the output backs up stage by stage; empty stages keep filling.
// Reset (rst_n low, synchronous) empties the pipeline and loads the identity
//   quaternion (x = y = z = 0, w = 16384).
module quaternion_vector_rotate_core #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration port
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [qvr_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [qvr_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [qvr_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [qvr_pkg::COORD_W-1:0] in_point_x,
  input  logic signed [qvr_pkg::COORD_W-1:0] in_point_y,
  input  logic signed [qvr_pkg::COORD_W-1:0] in_point_z,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [qvr_pkg::COORD_W-1:0] out_rotated_x,
  output logic signed [qvr_pkg::COORD_W-1:0] out_rotated_y,
  output logic signed [qvr_pkg::COORD_W-1:0] out_rotated_z,
  output logic                              out_saturated
);
  import qvr_pkg::*;

  localparam int PROD_SHIFT = 2 * QUAT_FRAC_BITS;
  localparam int SUM_W = (PROD_SHIFT + 2 > SUM_MIN_W) ? PROD_SHIFT + 2 : SUM_MIN_W;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'd1 << (PROD_SHIFT - 1));

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [QUAT_W-1:0] quat_x_r, quat_y_r, quat_z_r, quat_w_r;
  logic                     cfg_wr;
  qvr_reg_t                 cfg_reg;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_reg    = qvr_reg_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quat_x_r <= QUAT_V_RESET;
      quat_y_r <= QUAT_V_RESET;
      quat_z_r <= QUAT_V_RESET;
      quat_w_r <= QUAT_W_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_reg)
        REG_QUAT_X: quat_x_r <= cfg_pwdata[QUAT_W-1:0];
        REG_QUAT_Y: quat_y_r <= cfg_pwdata[QUAT_W-1:0];
        REG_QUAT_Z: quat_z_r <= cfg_pwdata[QUAT_W-1:0];
        REG_QUAT_W: quat_w_r <= cfg_pwdata[QUAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (cfg_reg)
      REG_QUAT_X: cfg_prdata = CFG_DATA_W'(quat_x_r[QUAT_W-1:0]);
      REG_QUAT_Y: cfg_prdata = CFG_DATA_W'(quat_y_r[QUAT_W-1:0]);
      REG_QUAT_Z: cfg_prdata = CFG_DATA_W'(quat_z_r[QUAT_W-1:0]);
      REG_QUAT_W: cfg_prdata = CFG_DATA_W'(quat_w_r[QUAT_W-1:0]);
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage valids and per-stage advance
  // ---------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic en1, en2, en3, en4, en5;
  logic v1_nxt, v2_nxt, v3_nxt, v4_nxt, v5_nxt;

  // A stage loads when it is empty or its content moves on
  assign en5 = ~v5_r | out_ready;
  assign en4 = ~v4_r | en5;
  assign en3 = ~v3_r | en4;
  assign en2 = ~v2_r | en3;
  assign en1 = ~v1_r | en2;
  assign in_ready = en1;

  assign v1_nxt = en1 ? in_valid : v1_r;
  assign v2_nxt = en2 ? v1_r     : v2_r;
  assign v3_nxt = en3 ? v2_r     : v3_r;
  assign v4_nxt = en4 ? v3_r     : v4_r;
  assign v5_nxt = en5 ? v4_r     : v5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
      v5_r <= v5_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: all 16x16 products
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] p1x_r, p1y_r, p1z_r;
  logic signed [PROD_W-1:0]  xx1_r, yy1_r, zz1_r, ww1_r;
  logic signed [PROD_W-1:0]  xpx1_r, ypy1_r, zpz1_r;
  logic signed [PROD_W-1:0]  ypz1_r, zpy1_r, zpx1_r, xpz1_r, xpy1_r, ypx1_r;

  always_ff @(posedge clk) begin
    if (en1) begin
      p1x_r  <= in_point_x;
      p1y_r  <= in_point_y;
      p1z_r  <= in_point_z;
      xx1_r  <= PROD_W'(quat_x_r * quat_x_r);
      yy1_r  <= PROD_W'(quat_y_r * quat_y_r);
      zz1_r  <= PROD_W'(quat_z_r * quat_z_r);
      ww1_r  <= PROD_W'(quat_w_r * quat_w_r);
      xpx1_r <= PROD_W'(quat_x_r * in_point_x);
      ypy1_r <= PROD_W'(quat_y_r * in_point_y);
      zpz1_r <= PROD_W'(quat_z_r * in_point_z);
      ypz1_r <= PROD_W'(quat_y_r * in_point_z);
      zpy1_r <= PROD_W'(quat_z_r * in_point_y);
      zpx1_r <= PROD_W'(quat_z_r * in_point_x);
      xpz1_r <= PROD_W'(quat_x_r * in_point_z);
      xpy1_r <= PROD_W'(quat_x_r * in_point_y);
      ypx1_r <= PROD_W'(quat_y_r * in_point_x);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: scale, dot product, cross product
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] p2x_r, p2y_r, p2z_r;
  logic signed [SCALE_W-1:0] scale2_r, dot2_r;
  logic signed [CROSS_W-1:0] cx2_r, cy2_r, cz2_r;
  logic signed [SCALE_W-1:0] scale_nxt, dot_nxt;
  logic signed [CROSS_W-1:0] cx_nxt, cy_nxt, cz_nxt;

  always_comb begin
    scale_nxt = SCALE_W'(ww1_r) - (SCALE_W'(xx1_r) + SCALE_W'(yy1_r) + SCALE_W'(zz1_r));
    dot_nxt   = SCALE_W'(xpx1_r) + SCALE_W'(ypy1_r) + SCALE_W'(zpz1_r);
    cx_nxt    = CROSS_W'(ypz1_r) - CROSS_W'(zpy1_r);
    cy_nxt    = CROSS_W'(zpx1_r) - CROSS_W'(xpz1_r);
    cz_nxt    = CROSS_W'(xpy1_r) - CROSS_W'(ypx1_r);
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      p2x_r    <= p1x_r;
      p2y_r    <= p1y_r;
      p2z_r    <= p1z_r;
      scale2_r <= scale_nxt;
      dot2_r   <= dot_nxt;
      cx2_r    <= cx_nxt;
      cy2_r    <= cy_nxt;
      cz2_r    <= cz_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: scale*p, dot*v, w*(v x p)
  // ---------------------------------------------------------------------------
  logic signed [TERM_W-1:0] a3x_r, a3y_r, a3z_r;
  logic signed [TERM_W-1:0] b3x_r, b3y_r, b3z_r;
  logic signed [TERM_W-1:0] c3x_r, c3y_r, c3z_r;

  always_ff @(posedge clk) begin
    if (en3) begin
      a3x_r <= TERM_W'(scale2_r * p2x_r);
      a3y_r <= TERM_W'(scale2_r * p2y_r);
      a3z_r <= TERM_W'(scale2_r * p2z_r);
      b3x_r <= TERM_W'(dot2_r * quat_x_r);
      b3y_r <= TERM_W'(dot2_r * quat_y_r);
      b3z_r <= TERM_W'(dot2_r * quat_z_r);
      c3x_r <= TERM_W'(cx2_r * quat_w_r);
      c3y_r <= TERM_W'(cy2_r * quat_w_r);
      c3z_r <= TERM_W'(cz2_r * quat_w_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: full sums plus rounding half
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] s4x_r, s4y_r, s4z_r;
  logic signed [SUM_W-1:0] sx_nxt, sy_nxt, sz_nxt;

  always_comb begin
    sx_nxt = SUM_W'(a3x_r) + (SUM_W'(b3x_r) <<< 1) + (SUM_W'(c3x_r) <<< 1) + ROUND_HALF;
    sy_nxt = SUM_W'(a3y_r) + (SUM_W'(b3y_r) <<< 1) + (SUM_W'(c3y_r) <<< 1) + ROUND_HALF;
    sz_nxt = SUM_W'(a3z_r) + (SUM_W'(b3z_r) <<< 1) + (SUM_W'(c3z_r) <<< 1) + ROUND_HALF;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4x_r <= sx_nxt;
      s4y_r <= sy_nxt;
      s4z_r <= sz_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: shift, saturate, output register
  // ---------------------------------------------------------------------------
  logic signed [COORD_W-1:0] rx_nxt, ry_nxt, rz_nxt;
  logic                      clip_x, clip_y, clip_z;
  logic signed [COORD_W-1:0] rx_r, ry_r, rz_r;
  logic                      sat_r;

  qvr_round_sat #(.SUM_W(SUM_W), .SHIFT(PROD_SHIFT)) u_rs_x (
    .biased_sum (s4x_r),
    .coord      (rx_nxt),
    .clip       (clip_x)
  );

  qvr_round_sat #(.SUM_W(SUM_W), .SHIFT(PROD_SHIFT)) u_rs_y (
    .biased_sum (s4y_r),
    .coord      (ry_nxt),
    .clip       (clip_y)
  );

  qvr_round_sat #(.SUM_W(SUM_W), .SHIFT(PROD_SHIFT)) u_rs_z (
    .biased_sum (s4z_r),
    .coord      (rz_nxt),
    .clip       (clip_z)
  );

  always_ff @(posedge clk) begin
    if (en5) begin
      rx_r  <= rx_nxt;
      ry_r  <= ry_nxt;
      rz_r  <= rz_nxt;
      sat_r <= clip_x | clip_y | clip_z;
    end
  end

  assign out_valid     = v5_r;
  assign out_rotated_x = rx_r;
  assign out_rotated_y = ry_r;
  assign out_rotated_z = rz_r;
  assign out_saturated = sat_r;

endmodule

[rtl/qvr_checker.sv]
// Port-level checks for the quaternion vector rotation core, bound to the top level.
module qvr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [qvr_pkg::COORD_W-1:0] out_rotated_x,
  input logic signed [qvr_pkg::COORD_W-1:0] out_rotated_y,
  input logic signed [qvr_pkg::COORD_W-1:0] out_rotated_z,
  input logic                              out_saturated
);
  import qvr_pkg::*;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_rotated_x) && $stable(out_rotated_y) &&
      $stable(out_rotated_z) && $stable(out_saturated))
    else $error("stalled result changed or dropped");

  // With the output draining, the pipeline always takes a new request
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // A clipped result shows at least one coordinate at a range limit
  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_rotated_x == COORD_MAX) || (out_rotated_x == COORD_MIN) ||
      (out_rotated_y == COORD_MAX) || (out_rotated_y == COORD_MIN) ||
      (out_rotated_z == COORD_MAX) || (out_rotated_z == COORD_MIN))
    else $error("saturation flag without a clipped coordinate");

  // An accepted request yields a valid result at the output when out_ready stays high behind it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
      |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind quaternion_vector_rotate_core qvr_checker u_qvr_checker (.*);

[tb/quaternion_vector_rotate_core_tb.sv]
// Testbench for quaternion_vector_rotate_core: checks streamed point rotations against a predictor.
module quaternion_vector_rotate_core_tb;
  import qvr_pkg::*;

  localparam int ROT_SHIFT   = 2 * QUAT_FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 68;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      sat;
  } rotated_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic signed [COORD_W-1:0] in_point_x = '0;
  logic signed [COORD_W-1:0] in_point_y = '0;
  logic signed [COORD_W-1:0] in_point_z = '0;

  logic                      out_valid;
  logic                      out_ready = 1'b1;
  logic signed [COORD_W-1:0] out_rotated_x;
  logic signed [COORD_W-1:0] out_rotated_y;
  logic signed [COORD_W-1:0] out_rotated_z;
  logic                      out_saturated;

  // Predictor copy of the quaternion registers
  logic signed [QUAT_W-1:0] quat_reg [4];

  point_t   point_q [$];
  rotated_t rotated_q [$];

  int  pushed_cnt = 0;
  int  sent_cnt = 0;
  int  accepted_cnt = 0;
  int  checked_cnt = 0;
  int  sat_cnt = 0;
  int  fail_cnt = 0;
  int  setting_cnt = 0;
  int  cycle_cnt = 0;
  int  in_gap = 0;
  int  out_stall = 0;
  bit  idle_en = 1'b1;

  quaternion_vector_rotate_core DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_psel     (cfg_psel),
    .cfg_penable  (cfg_penable),
    .cfg_pwrite   (cfg_pwrite),
    .cfg_paddr    (cfg_paddr),
    .cfg_pwdata   (cfg_pwdata),
    .cfg_prdata   (cfg_prdata),
    .cfg_pready   (cfg_pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_point_z   (in_point_z),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_rotated_x(out_rotated_x),
    .out_rotated_y(out_rotated_y),
    .out_rotated_z(out_rotated_z),
    .out_saturated(out_saturated)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Round half up, drop the product fraction bits, clip to 16 bits
  function automatic logic signed [COORD_W-1:0] round_clip(input longint sum, inout logic clip);
    longint q;
    q = (sum + (longint'(1) << (ROT_SHIFT - 1))) >>> ROT_SHIFT;
    if (q > 32767) begin
      clip = 1'b1;
      return COORD_MAX;
    end
    if (q < -32768) begin
      clip = 1'b1;
      return COORD_MIN;
    end
    return q[COORD_W-1:0];
  endfunction

  // p' = (w^2 - v.v) p + 2 (v.p) v + 2 w (v x p), full precision
  function automatic rotated_t rotate_point(input point_t p);
    longint   qx, qy, qz, qw, px, py, pz;
    longint   scale, dot, cx, cy, cz;
    rotated_t r;
    logic     clip;
    qx = quat_reg[REG_QUAT_X];
    qy = quat_reg[REG_QUAT_Y];
    qz = quat_reg[REG_QUAT_Z];
    qw = quat_reg[REG_QUAT_W];
    px = p.x;
    py = p.y;
    pz = p.z;
    scale = qw * qw - (qx * qx + qy * qy + qz * qz);
    dot   = qx * px + qy * py + qz * pz;
    cx    = qy * pz - qz * py;
    cy    = qz * px - qx * pz;
    cz    = qx * py - qy * px;
    clip  = 1'b0;
    r.x   = round_clip(scale * px + 2 * dot * qx + 2 * qw * cx, clip);
    r.y   = round_clip(scale * py + 2 * dot * qy + 2 * qw * cy, clip);
    r.z   = round_clip(scale * pz + 2 * dot * qz + 2 * qw * cz, clip);
    r.sat = clip;
    return r;
  endfunction

  // Mix of full-range, small and corner coordinates
  function automatic logic signed [COORD_W-1:0] pick_coord();
    logic signed [COORD_W-1:0] corners [6];
    corners = '{16'sh8000, 16'sh8001, -16'sd1, 16'sd0, 16'sd1, 16'sh7FFF};
    case ($urandom_range(0, 3))
      0, 1: return COORD_W'($urandom);
      2: return COORD_W'(int'($urandom_range(0, 2000)) - 1000);
      default: return corners[$urandom_range(0, 5)];
    endcase
  endfunction

  // One APB write: setup cycle, then access cycle until pready
  task automatic write_quat(input qvr_reg_t idx, input logic [QUAT_W-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {16'($urandom), val};  // upper bits must be ignored
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    quat_reg[idx] = val;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_quat(input int x, input int y, input int z, input int w);
    write_quat(REG_QUAT_X, QUAT_W'(x));
    write_quat(REG_QUAT_Y, QUAT_W'(y));
    write_quat(REG_QUAT_Z, QUAT_W'(z));
    write_quat(REG_QUAT_W, QUAT_W'(w));
    setting_cnt++;
  endtask

  task automatic push_point(input int x, input int y, input int z);
    point_t p;
    p.x = COORD_W'(x);
    p.y = COORD_W'(y);
    p.z = COORD_W'(z);
    point_q.push_back(p);
    pushed_cnt++;
  endtask

  // Hold off until every request has been accepted and every result checked
  task automatic wait_drain();
    while (accepted_cnt != pushed_cnt || rotated_q.size() != 0) @(negedge clk);
  endtask

  // Request driver
  always @(negedge clk) begin : drive_points
    point_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && accepted_cnt != sent_cnt) begin
      // hold the pending request
    end else if (in_gap > 0) begin
      in_gap--;
      in_valid <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      in_gap = $urandom_range(0, 5);
      in_valid <= 1'b0;
    end else if (point_q.size() > 0) begin
      p = point_q.pop_front();
      in_point_x <= p.x;
      in_point_y <= p.y;
      in_point_z <= p.z;
      in_valid   <= 1'b1;
      sent_cnt++;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result backpressure in bursts
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Predict on accepted requests, check accepted results
  always @(posedge clk) begin : track
    point_t   p;
    rotated_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        p.x = in_point_x;
        p.y = in_point_y;
        p.z = in_point_z;
        rotated_q.push_back(rotate_point(p));
        accepted_cnt++;
      end
      if (out_valid && out_ready) begin
        if (rotated_q.size() == 0) begin
          $error("result with no pending request: x=%0d y=%0d z=%0d",
                 out_rotated_x, out_rotated_y, out_rotated_z);
          fail_cnt++;
        end else begin
          want = rotated_q.pop_front();
          checked_cnt++;
          if (out_saturated) sat_cnt++;
          if (out_rotated_x !== want.x) begin
            $error("rotated_x: expected %0d, got %0d", want.x, out_rotated_x);
            fail_cnt++;
          end
          if (out_rotated_y !== want.y) begin
            $error("rotated_y: expected %0d, got %0d", want.y, out_rotated_y);
            fail_cnt++;
          end
          if (out_rotated_z !== want.z) begin
            $error("rotated_z: expected %0d, got %0d", want.z, out_rotated_z);
            fail_cnt++;
          end
          if (out_saturated !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, out_saturated);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus sequence
  initial begin
    int mode;
    int axis;
    int sgn;
    int q [4];
    quat_reg[REG_QUAT_X] = QUAT_V_RESET;
    quat_reg[REG_QUAT_Y] = QUAT_V_RESET;
    quat_reg[REG_QUAT_Z] = QUAT_V_RESET;
    quat_reg[REG_QUAT_W] = QUAT_W_RESET;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Identity quaternion out of reset
    push_point(32767, -32768, 0);
    push_point(-32768, 32767, -1);
    push_point(1, -1, 0);
    push_point(0, 0, 0);
    push_point(12345, -23456, 777);
    wait_drain();

    // w = 0.5 scales by 1/4: exact half-way sums, ties go up
    set_quat(0, 0, 0, 8192);
    push_point(2, -2, 6);
    push_point(-6, 1, -1);
    push_point(3, 2, -2);
    wait_drain();

    // 90 degrees about z
    set_quat(0, 0, 11585, 11585);
    push_point(1000, 0, 0);
    push_point(0, 1000, 0);
    push_point(32767, -32768, 5);
    wait_drain();

    // Non-unit quaternions at the register extremes
    set_quat(32767, 32767, 32767, 32767);
    push_point(32767, 32767, 32767);
    push_point(-32768, -32768, -32768);
    push_point(100, -200, 300);
    wait_drain();
    set_quat(-32768, -32768, -32768, -32768);
    push_point(32767, 32767, 32767);
    push_point(-32768, -32768, -32768);
    push_point(100, -200, 300);
    wait_drain();

    // Pure scaling by about four, clipping both ways
    set_quat(0, 0, 0, 32767);
    push_point(20000, -20000, 16383);
    push_point(-8192, 8191, 0);
    wait_drain();

    // Zero quaternion collapses every point
    set_quat(0, 0, 0, 0);
    push_point(32767, -32768, 1);
    wait_drain();

    // Random phases, each under its own quaternion; the last one runs without idling
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      mode = ph % 4;
      for (int i = 0; i < 4; i++) begin
        case (mode)
          0: q[i] = int'($urandom_range(0, 65535)) - 32768;
          1: q[i] = int'($urandom_range(0, 32768)) - 16384;
          2: q[i] = 0;
          default: q[i] = ($urandom_range(0, 2) == 0) ? 0 :
                          (($urandom_range(0, 1) == 0) ? 32767 : -32768);
        endcase
      end
      if (mode == 2) begin
        axis = $urandom_range(0, 2);
        sgn  = ($urandom_range(0, 1) == 0) ? 1 : -1;
        q[axis] = sgn * 11585;
        q[3]    = 11585;
      end
      set_quat(q[0], q[1], q[2], q[3]);
      if (ph == RAND_PHASES - 1) idle_en = 1'b0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        push_point(pick_coord(), pick_coord(), pick_coord());
      end
      wait_drain();
    end

    repeat (20) @(posedge clk);
    $display("Rotated %0d points under %0d quaternion settings; %0d results saturated.",
             checked_cnt, setting_cnt + 1, sat_cnt);
    if (fail_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[quaternion_vector_rotate_core.f]
rtl/qvr_pkg.sv
rtl/qvr_round_sat.sv
rtl/quaternion_vector_rotate_core.sv
rtl/qvr_checker.sv
tb/quaternion_vector_rotate_core_tb.sv
